// ----- hdl/edc_pkg.sv -----
// Shared types, constants and calendar table functions for the epoch/date converter.
// No dependencies; used by edc_sec_to_date, edc_date_to_sec and epoch_date_converter.
package edc_pkg;

   // pipeline depth, shared by both datapaths and the valid chain
   localparam int NUM_STAGES = 7;

   // calendar constants
   localparam int CYCLE_DAYS   = 365 * 4 + 1;
   localparam int YEAR_DAYS    = 365;
   localparam int SECS_PER_MIN = 60;
   localparam int MINS_PER_HR  = 60;
   localparam int HRS_PER_DAY  = 24;

   // reciprocals for constant division, exact over the operand ranges used
   localparam logic [31:0] RECIP_60   = 32'h8888_8889; // x / 60   = (x * r) >> 37, x < 2^32
   localparam logic [17:0] RECIP_3    = 18'd174763;    // x / 3    = (x * r) >> 19, x < 2^19
   localparam logic [15:0] RECIP_1461 = 16'd45934;     // x / 1461 = (x * r) >> 26, x < 2^16

   localparam logic [1:0] LEAP_SLOT_RESET = 2'd2;

   typedef enum logic {
      CMD_TO_DATE  = 1'b0,
      CMD_TO_EPOCH = 1'b1
   } command_type;

   // per-stage advance enables and the leap slot, from the control to the datapaths
   typedef struct packed {
      logic [1:0]            leap_slot;
      logic [NUM_STAGES-1:0] adv;
   } ctrl_type;

   // days before the first of month m (zero based) in a common year
   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // days before month m within its year, with the leap day after february
   function automatic logic [8:0] month_offset(input logic [3:0] m, input logic leap);
      logic [8:0] d;
      d = month_start(m);
      if (leap && (m >= 4'd2)) begin
         d = d + 9'd1;
      end
      return d;
   endfunction

   // days from the cycle start to the first day of year slot s
   function automatic logic [10:0] year_base(input logic [1:0] s, input logic [1:0] leap_slot);
      logic [10:0] d;
      d = 11'(s) * 11'(YEAR_DAYS);
      if (s > leap_slot) begin
         d = d + 11'd1;
      end
      return d;
   endfunction

endpackage

// ----- hdl/epoch_date_converter.sv -----
// Pipeline: a request transfer loads stage 0 and rsp_valid is the valid bit of the last
// stage, so 7 register stages lie from request to response.
// Throughput: one conversion per cycle while rsp_stall stays low; both datapaths run as
// 7-stage pipelines and a stage moves on whenever the stage after it is empty or moving.
// Reset (synchronous, active high) empties the pipeline and sets leap_slot to 2.
// Top level: channels, leap slot register, valid chain; uses edc_pkg and both datapaths.
module epoch_date_converter (
   input  logic        clock,
   input  logic        reset,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_leap_slot,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_epoch_in,
   input  logic [5:0]  req_second_in,
   input  logic [5:0]  req_minute_in,
   input  logic [4:0]  req_hour_in,
   input  logic [4:0]  req_day_in,
   input  logic [3:0]  req_month_in,
   input  logic [7:0]  req_year_in,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_epoch_out,
   output logic [5:0]  rsp_second_out,
   output logic [5:0]  rsp_minute_out,
   output logic [4:0]  rsp_hour_out,
   output logic [4:0]  rsp_day_out,
   output logic [3:0]  rsp_month_out,
   output logic [7:0]  rsp_year_out,
   output logic        rsp_bad_month
);
   import edc_pkg::*;

   // leap slot register, written by a configuration transfer
   logic [1:0] leap_slot_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         leap_slot_ff <= LEAP_SLOT_RESET;
      end else if (csr_valid && csr_ready) begin
         leap_slot_ff <= csr_leap_slot;
      end
   end

   // stage advance: a stage loads when it is empty or the next one moves
   logic [NUM_STAGES-1:0] valid_ff, valid_in, adv;
   command_type           cmd_ff [NUM_STAGES];

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];

   // valid bits travel with the data
   always_comb begin
      valid_in = valid_ff;
      if (adv[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // command travels beside the valid bits
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cmd_ff[0] <= command_type'(req_command);
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            cmd_ff[k] <= cmd_ff[k-1];
         end
      end
   end

   // datapaths
   ctrl_type    ctrl;
   logic [5:0]  s2d_second, s2d_minute;
   logic [4:0]  s2d_hour, s2d_day;
   logic [3:0]  s2d_month;
   logic [7:0]  s2d_year;
   logic [31:0] d2s_epoch;
   logic        d2s_bad_month;

   assign ctrl.leap_slot = leap_slot_ff;
   assign ctrl.adv       = adv;

   edc_sec_to_date u_sec_to_date (
      .clock  (clock),
      .ctrl   (ctrl),
      .epoch  (req_epoch_in),
      .second (s2d_second),
      .minute (s2d_minute),
      .hour   (s2d_hour),
      .day    (s2d_day),
      .month  (s2d_month),
      .year   (s2d_year)
   );

   edc_date_to_sec u_date_to_sec (
      .clock     (clock),
      .ctrl      (ctrl),
      .second    (req_second_in),
      .minute    (req_minute_in),
      .hour      (req_hour_in),
      .day       (req_day_in),
      .month     (req_month_in),
      .year      (req_year_in),
      .epoch     (d2s_epoch),
      .bad_month (d2s_bad_month)
   );

   // response: fields of the other direction read as zero
   logic to_epoch;

   assign to_epoch       = (cmd_ff[NUM_STAGES-1] == CMD_TO_EPOCH);
   assign rsp_valid      = valid_ff[NUM_STAGES-1];
   assign rsp_epoch_out  = to_epoch ? d2s_epoch : 32'd0;
   assign rsp_bad_month  = to_epoch ? d2s_bad_month : 1'b0;
   assign rsp_second_out = to_epoch ? 6'd0 : s2d_second;
   assign rsp_minute_out = to_epoch ? 6'd0 : s2d_minute;
   assign rsp_hour_out   = to_epoch ? 5'd0 : s2d_hour;
   assign rsp_day_out    = to_epoch ? 5'd0 : s2d_day;
   assign rsp_month_out  = to_epoch ? 4'd0 : s2d_month;
   assign rsp_year_out   = to_epoch ? 8'd0 : s2d_year;

`ifndef SYNTHESIS
   // a request is held off only when every stage holds an item
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("request stalled with an empty pipeline stage");

   // time of day from the divider chain stays in range
   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !to_epoch) |->
         (rsp_second_out < 6'd60 && rsp_minute_out < 6'd60 && rsp_hour_out < 5'd24))
      else $error("time of day out of range");

   // month and day from the table search stay in range
   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !to_epoch) |->
         (rsp_day_out != 5'd0 && rsp_month_out >= 4'd1 && rsp_month_out <= 4'd12))
      else $error("month or day out of range");
`endif

endmodule

// ----- hdl/edc_sec_to_date.sv -----
// Seconds count to calendar fields datapath, seven register stages.
// Depends on edc_pkg for the reciprocal constants and the calendar table functions.
module edc_sec_to_date (
   input  logic              clock,
   input  edc_pkg::ctrl_type ctrl,
   input  logic [31:0]       epoch,
   output logic [5:0]        second,
   output logic [5:0]        minute,
   output logic [4:0]        hour,
   output logic [4:0]        day,
   output logic [3:0]        month,
   output logic [7:0]        year
);
   import edc_pkg::*;

   // stage 0: seconds / 60
   logic [31:0] e0_ff;
   logic [26:0] q1_0_ff, q1_0_in;
   logic [63:0] prod1;

   always_comb begin
      prod1   = 64'(epoch) * 64'(RECIP_60);
      q1_0_in = prod1[63:37];
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         e0_ff   <= epoch;
         q1_0_ff <= q1_0_in;
      end
   end

   // stage 1: second of minute, minutes / 60
   logic [5:0]  sec1_ff, sec1_in;
   logic [26:0] q1_1_ff;
   logic [20:0] q2_1_ff, q2_1_in;
   logic [31:0] rem60_1;
   logic [58:0] prod2;

   always_comb begin
      rem60_1 = e0_ff - 32'(q1_0_ff) * 32'(SECS_PER_MIN);
      sec1_in = rem60_1[5:0];
      prod2   = 59'(q1_0_ff) * 59'(RECIP_60);
      q2_1_in = prod2[57:37];
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[1]) begin
         sec1_ff <= sec1_in;
         q1_1_ff <= q1_0_ff;
         q2_1_ff <= q2_1_in;
      end
   end

   // stage 2: minute of hour, hours / 24 as (hours / 8) / 3
   logic [5:0]  sec2_ff, min2_ff, min2_in;
   logic [20:0] q2_2_ff;
   logic [15:0] q3_2_ff, q3_2_in;
   logic [26:0] rem60_2;
   logic [37:0] prod3;

   always_comb begin
      rem60_2 = q1_1_ff - 27'(q2_1_ff) * 27'(MINS_PER_HR);
      min2_in = rem60_2[5:0];
      prod3   = 38'(q2_1_ff[20:3]) * 38'(RECIP_3);
      q3_2_in = prod3[34:19];
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[2]) begin
         sec2_ff <= sec1_ff;
         min2_ff <= min2_in;
         q2_2_ff <= q2_1_ff;
         q3_2_ff <= q3_2_in;
      end
   end

   // stage 3: hour of day, days / 1461
   logic [5:0]  sec3_ff, min3_ff;
   logic [4:0]  hr3_ff, hr3_in;
   logic [15:0] days3_ff;
   logic [5:0]  cyc3_ff, cyc3_in;
   logic [20:0] rem24_3;
   logic [31:0] prod4;

   always_comb begin
      rem24_3 = q2_2_ff - 21'(q3_2_ff) * 21'(HRS_PER_DAY);
      hr3_in  = rem24_3[4:0];
      prod4   = 32'(q3_2_ff) * 32'(RECIP_1461);
      cyc3_in = prod4[31:26];
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[3]) begin
         sec3_ff  <= sec2_ff;
         min3_ff  <= min2_ff;
         hr3_ff   <= hr3_in;
         days3_ff <= q3_2_ff;
         cyc3_ff  <= cyc3_in;
      end
   end

   // stage 4: day within the four-year cycle
   logic [5:0]  sec4_ff, min4_ff;
   logic [4:0]  hr4_ff;
   logic [10:0] rem4_ff, rem4_in;
   logic [7:0]  yrs4_ff, yrs4_in;
   logic [15:0] rem1461_4;

   always_comb begin
      rem1461_4 = days3_ff - 16'(cyc3_ff) * 16'(CYCLE_DAYS);
      rem4_in   = rem1461_4[10:0];
      yrs4_in   = {cyc3_ff, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[4]) begin
         sec4_ff <= sec3_ff;
         min4_ff <= min3_ff;
         hr4_ff  <= hr3_ff;
         rem4_ff <= rem4_in;
         yrs4_ff <= yrs4_in;
      end
   end

   // stage 5: year slot by comparison against the year starts
   logic [5:0]  sec5_ff, min5_ff;
   logic [4:0]  hr5_ff;
   logic [7:0]  yr5_ff, yr5_in;
   logic [8:0]  doy5_ff, doy5_in;
   logic        leap5_ff, leap5_in;
   logic [1:0]  slot5;
   logic [10:0] base5, doy_full5;

   always_comb begin
      if (rem4_ff >= year_base(2'd3, ctrl.leap_slot)) begin
         slot5 = 2'd3;
      end else if (rem4_ff >= year_base(2'd2, ctrl.leap_slot)) begin
         slot5 = 2'd2;
      end else if (rem4_ff >= year_base(2'd1, ctrl.leap_slot)) begin
         slot5 = 2'd1;
      end else begin
         slot5 = 2'd0;
      end
      base5     = year_base(slot5, ctrl.leap_slot);
      doy_full5 = rem4_ff - base5;
      doy5_in   = doy_full5[8:0];
      yr5_in    = yrs4_ff + 8'(slot5);
      leap5_in  = (slot5 == ctrl.leap_slot);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[5]) begin
         sec5_ff  <= sec4_ff;
         min5_ff  <= min4_ff;
         hr5_ff   <= hr4_ff;
         yr5_ff   <= yr5_in;
         doy5_ff  <= doy5_in;
         leap5_ff <= leap5_in;
      end
   end

   // stage 6: month by comparison against the month starts, then day of month
   logic [5:0] sec6_ff, min6_ff;
   logic [4:0] hr6_ff;
   logic [7:0] yr6_ff;
   logic [3:0] mon6_ff, mon6_in;
   logic [4:0] day6_ff, day6_in;
   logic [3:0] mon_idx6;
   logic [8:0] day_full6;

   always_comb begin
      mon_idx6 = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy5_ff >= month_offset(4'(m), leap5_ff)) begin
            mon_idx6 = 4'(m);
         end
      end
      day_full6 = doy5_ff - month_offset(mon_idx6, leap5_ff) + 9'd1;
      day6_in   = day_full6[4:0];
      mon6_in   = mon_idx6 + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[6]) begin
         sec6_ff <= sec5_ff;
         min6_ff <= min5_ff;
         hr6_ff  <= hr5_ff;
         yr6_ff  <= yr5_ff;
         mon6_ff <= mon6_in;
         day6_ff <= day6_in;
      end
   end

   assign second = sec6_ff;
   assign minute = min6_ff;
   assign hour   = hr6_ff;
   assign day    = day6_ff;
   assign month  = mon6_ff;
   assign year   = yr6_ff;

endmodule

// ----- hdl/edc_date_to_sec.sv -----
// Calendar fields to seconds count datapath, seven register stages, result modulo 2^32.
// Depends on edc_pkg for the calendar constants and the table functions.
module edc_date_to_sec (
   input  logic              clock,
   input  edc_pkg::ctrl_type ctrl,
   input  logic [5:0]        second,
   input  logic [5:0]        minute,
   input  logic [4:0]        hour,
   input  logic [4:0]        day,
   input  logic [3:0]        month,
   input  logic [7:0]        year,
   output logic [31:0]       epoch,
   output logic              bad_month
);
   import edc_pkg::*;

   // stage 0: month check, day minus one, days into the cycle from the table
   logic [5:0]  sec0_ff, min0_ff;
   logic [4:0]  hr0_ff;
   logic [31:0] dm1_0_ff, dm1_0_in;
   logic [10:0] tdays0_ff, tdays0_in;
   logic [5:0]  ycyc0_ff;
   logic        bad0_ff, bad0_in;
   logic [3:0]  moff0;

   always_comb begin
      bad0_in   = (month < 4'd1) || (month > 4'd12);
      moff0     = bad0_in ? 4'd0 : (month - 4'd1);
      dm1_0_in  = 32'(day) - 32'd1;
      tdays0_in = year_base(year[1:0], ctrl.leap_slot)
                + 11'(month_offset(moff0, year[1:0] == ctrl.leap_slot));
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         sec0_ff   <= second;
         min0_ff   <= minute;
         hr0_ff    <= hour;
         dm1_0_ff  <= dm1_0_in;
         tdays0_ff <= tdays0_in;
         ycyc0_ff  <= year[7:2];
         bad0_ff   <= bad0_in;
      end
   end

   // stage 1: total day count
   logic [5:0]  sec1_ff, min1_ff;
   logic [4:0]  hr1_ff;
   logic [31:0] days1_ff, days1_in;
   logic        bad1_ff;

   always_comb begin
      days1_in = 32'(ycyc0_ff) * 32'(CYCLE_DAYS) + 32'(tdays0_ff) + dm1_0_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[1]) begin
         sec1_ff  <= sec0_ff;
         min1_ff  <= min0_ff;
         hr1_ff   <= hr0_ff;
         days1_ff <= days1_in;
         bad1_ff  <= bad0_ff;
      end
   end

   // stage 2: hours
   logic [5:0]  sec2_ff, min2_ff;
   logic [31:0] t2_ff, t2_in;
   logic        bad2_ff;

   always_comb begin
      t2_in = days1_ff * 32'(HRS_PER_DAY) + 32'(hr1_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[2]) begin
         sec2_ff <= sec1_ff;
         min2_ff <= min1_ff;
         t2_ff   <= t2_in;
         bad2_ff <= bad1_ff;
      end
   end

   // stage 3: minutes
   logic [5:0]  sec3_ff;
   logic [31:0] t3_ff, t3_in;
   logic        bad3_ff;

   always_comb begin
      t3_in = t2_ff * 32'(MINS_PER_HR) + 32'(min2_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[3]) begin
         sec3_ff <= sec2_ff;
         t3_ff   <= t3_in;
         bad3_ff <= bad2_ff;
      end
   end

   // stage 4: seconds
   logic [31:0] t4_ff, t4_in;
   logic        bad4_ff;

   always_comb begin
      t4_in = t3_ff * 32'(SECS_PER_MIN) + 32'(sec3_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[4]) begin
         t4_ff   <= t4_in;
         bad4_ff <= bad3_ff;
      end
   end

   // stages 5 and 6: delay to line up with the date path
   logic [31:0] t5_ff, t6_ff;
   logic        bad5_ff, bad6_ff;

   always_ff @(posedge clock) begin
      if (ctrl.adv[5]) begin
         t5_ff   <= t4_ff;
         bad5_ff <= bad4_ff;
      end
      if (ctrl.adv[6]) begin
         t6_ff   <= t5_ff;
         bad6_ff <= bad5_ff;
      end
   end

   assign epoch     = t6_ff;
   assign bad_month = bad6_ff;

endmodule

// ----- tb/sv/edc_result_checker.sv -----
`timescale 1ns / 1ps
// Conversion checker for epoch_date_converter: tracks the leap slot register,
// predicts each conversion from the request transfers and compares rsp transfers.
// Depends on edc_pkg for the command encoding and the leap slot reset value.
module edc_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_leap_slot,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_command,
   input  logic [31:0]       req_epoch_in,
   input  logic [5:0]        req_second_in,
   input  logic [5:0]        req_minute_in,
   input  logic [4:0]        req_hour_in,
   input  logic [4:0]        req_day_in,
   input  logic [3:0]        req_month_in,
   input  logic [7:0]        req_year_in,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [31:0]       rsp_epoch_out,
   input  logic [5:0]        rsp_second_out,
   input  logic [5:0]        rsp_minute_out,
   input  logic [4:0]        rsp_hour_out,
   input  logic [4:0]        rsp_day_out,
   input  logic [3:0]        rsp_month_out,
   input  logic [7:0]        rsp_year_out,
   input  logic              rsp_bad_month,
   output int unsigned       fail_count,
   output int unsigned       outstanding
);
   import edc_pkg::*;

   typedef struct packed {
      logic [31:0] epoch;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [7:0]  year;
      logic        bad_month;
   } calendar_result_type;

   logic [1:0]          leap_slot;
   calendar_result_type pending_conversions[$];

   // days from the start of the four-year cycle to the first of month mon in year slot
   function automatic int unsigned days_to_month(input int unsigned slot,
                                                 input int unsigned mon,
                                                 input logic [1:0] leap);
      int unsigned d;
      case (mon)
         1:       d = 31;
         2:       d = 59;
         3:       d = 90;
         4:       d = 120;
         5:       d = 151;
         6:       d = 181;
         7:       d = 212;
         8:       d = 243;
         9:       d = 273;
         10:      d = 304;
         11:      d = 334;
         default: d = 0;
      endcase
      d = d + 365 * slot;
      if (slot > leap) begin
         d = d + 1;
      end
      if (slot == leap && mon >= 2) begin
         d = d + 1;
      end
      return d;
   endfunction

   // seconds count to calendar fields
   function automatic calendar_result_type split_epoch(input logic [31:0] secs,
                                                       input logic [1:0] leap);
      calendar_result_type r;
      int unsigned rest, days, rem, slot, mon;
      r = '0;
      rest = secs;
      r.second = 6'(rest % 60);
      rest = rest / 60;
      r.minute = 6'(rest % 60);
      rest = rest / 60;
      r.hour = 5'(rest % 24);
      days = rest / 24;
      rem = days % 1461;
      slot = 3;
      while (slot > 0 && rem < days_to_month(slot, 0, leap)) begin
         slot = slot - 1;
      end
      mon = 11;
      while (mon > 0 && rem < days_to_month(slot, mon, leap)) begin
         mon = mon - 1;
      end
      r.day = 5'(rem - days_to_month(slot, mon, leap) + 1);
      r.month = 4'(mon + 1);
      r.year = 8'((days / 1461) * 4 + slot);
      return r;
   endfunction

   // calendar fields to seconds count, wrapping at 32 bits
   function automatic calendar_result_type join_date(input logic [5:0] s,
                                                     input logic [5:0] mi,
                                                     input logic [4:0] h,
                                                     input logic [4:0] d,
                                                     input logic [3:0] mo,
                                                     input logic [7:0] y,
                                                     input logic [1:0] leap);
      calendar_result_type r;
      logic [31:0]         total;
      int unsigned         moff;
      r = '0;
      r.bad_month = (mo < 4'd1 || mo > 4'd12);
      // a bad month counts from the start of the year
      moff = r.bad_month ? 0 : int'(mo) - 1;
      total = 32'(y / 8'd4) * 32'd1461 + 32'(days_to_month(y % 4, moff, leap))
              + (32'(d) - 32'd1);
      total = total * 32'd24 + 32'(h);
      total = total * 32'd60 + 32'(mi);
      total = total * 32'd60 + 32'(s);
      r.epoch = total;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   // watch all three channels on the rising edge
   always @(posedge clock) begin : monitor
      calendar_result_type want;
      if (reset) begin
         leap_slot = LEAP_SLOT_RESET;
         pending_conversions.delete();
      end else begin
         // result transfer against the oldest pending conversion
         if (rsp_valid && !rsp_stall) begin
            if (pending_conversions.size() == 0) begin
               $display("%0t: result transfer with no conversion pending, expected none, "
                        , $time, "actual epoch %0d", rsp_epoch_out);
               fail_count = fail_count + 1;
            end else begin
               want = pending_conversions.pop_front();
               compare_field("epoch_out", want.epoch, rsp_epoch_out);
               compare_field("second_out", want.second, rsp_second_out);
               compare_field("minute_out", want.minute, rsp_minute_out);
               compare_field("hour_out", want.hour, rsp_hour_out);
               compare_field("day_out", want.day, rsp_day_out);
               compare_field("month_out", want.month, rsp_month_out);
               compare_field("year_out", want.year, rsp_year_out);
               compare_field("bad_month", want.bad_month, rsp_bad_month);
            end
         end
         // request transfer
         if (req_valid && !req_stall) begin
            if (req_command == CMD_TO_EPOCH) begin
               pending_conversions.push_back(join_date(req_second_in, req_minute_in,
                  req_hour_in, req_day_in, req_month_in, req_year_in, leap_slot));
            end else begin
               pending_conversions.push_back(split_epoch(req_epoch_in, leap_slot));
            end
         end
         // register write
         if (csr_valid && csr_ready) begin
            leap_slot = csr_leap_slot;
         end
      end
      outstanding = pending_conversions.size();
   end

endmodule

// ----- tb/sv/tb_epoch_date_converter.sv -----
`timescale 1ns / 1ps
// Top of the epoch_date_converter testbench: clock, reset, stimulus and verdict.
// Depends on edc_pkg, the converter RTL and edc_result_checker.
module tb_epoch_date_converter;
   import edc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 228;
   localparam int SECS_PER_DAY  = 86400;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_leap_slot;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [31:0] req_epoch_in;
   logic [5:0]  req_second_in;
   logic [5:0]  req_minute_in;
   logic [4:0]  req_hour_in;
   logic [4:0]  req_day_in;
   logic [3:0]  req_month_in;
   logic [7:0]  req_year_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_epoch_out;
   logic [5:0]  rsp_second_out;
   logic [5:0]  rsp_minute_out;
   logic [4:0]  rsp_hour_out;
   logic [4:0]  rsp_day_out;
   logic [3:0]  rsp_month_out;
   logic [7:0]  rsp_year_out;
   logic        rsp_bad_month;

   int unsigned fail_count;
   int unsigned outstanding;
   int          idle_pct;
   int          stall_pct;
   int          cycle_count;

   epoch_date_converter dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_leap_slot  (csr_leap_slot),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_epoch_in   (req_epoch_in),
      .req_second_in  (req_second_in),
      .req_minute_in  (req_minute_in),
      .req_hour_in    (req_hour_in),
      .req_day_in     (req_day_in),
      .req_month_in   (req_month_in),
      .req_year_in    (req_year_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_epoch_out  (rsp_epoch_out),
      .rsp_second_out (rsp_second_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_year_out   (rsp_year_out),
      .rsp_bad_month  (rsp_bad_month)
   );

   edc_result_checker checker_inst (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < stall_pct);
   end

   // cycle limit
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $display("FAILURE");
      $finish;
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic send_request(input command_type cmd, input logic [31:0] epoch,
                               input logic [5:0] s, input logic [5:0] mi,
                               input logic [4:0] h, input logic [4:0] d,
                               input logic [3:0] mo, input logic [7:0] y);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_command   = cmd;
      req_epoch_in  = epoch;
      req_second_in = s;
      req_minute_in = mi;
      req_hour_in   = h;
      req_day_in    = d;
      req_month_in  = mo;
      req_year_in   = y;
      req_valid     = 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // wait for every conversion to come back, then let the pipeline settle
   task automatic drain_conversions();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (NUM_STAGES + 2) @(negedge clock);
   endtask

   task automatic write_leap_slot(input logic [1:0] slot);
      @(negedge clock);
      csr_leap_slot = slot;
      csr_valid = 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // random conversion, mostly near year and month boundaries or well-formed dates
   task automatic random_request();
      command_type cmd;
      longint      days;
      longint      sod;
      logic [31:0] epoch;
      logic [5:0]  s, mi;
      logic [4:0]  h, d;
      logic [3:0]  mo;
      logic [7:0]  y;
      int          pick;
      int          mon;
      cmd = $urandom_range(1) ? CMD_TO_EPOCH : CMD_TO_DATE;
      pick = $urandom_range(99);
      epoch = $urandom;
      // seconds count: boundary days, full range or the two ends
      if (pick < 60) begin
         mon = $urandom_range(11);
         days = longint'($urandom_range(34)) * 1461 + longint'($urandom_range(3)) * 365
                + (mon * 3059) / 100 - 3 + $urandom_range(6);
         if (days < 0) begin
            days = 0;
         end
         case ($urandom_range(2))
            0:       sod = 0;
            1:       sod = SECS_PER_DAY - 1;
            default: sod = $urandom_range(SECS_PER_DAY - 1);
         endcase
         epoch = 32'(days * SECS_PER_DAY + sod);
      end else if (pick < 75) begin
         epoch = $urandom_range(1) ? $urandom_range(200000)
                                   : 32'hFFFFFFFF - $urandom_range(200000);
      end
      // calendar fields: mostly in range, some anywhere the widths allow
      if ($urandom_range(3) != 0) begin
         s  = 6'($urandom_range(59));
         mi = 6'($urandom_range(59));
         h  = 5'($urandom_range(23));
         d  = 5'($urandom_range(31, 1));
         mo = 4'($urandom_range(12, 1));
         y  = 8'($urandom_range(136));
      end else begin
         s  = 6'($urandom);
         mi = 6'($urandom);
         h  = 5'($urandom);
         d  = 5'($urandom);
         mo = 4'($urandom);
         y  = 8'($urandom);
      end
      send_request(cmd, epoch, s, mi, h, d, mo, y);
   endtask

   // stimulus and verdict
   initial begin
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_leap_slot = LEAP_SLOT_RESET;
      req_valid     = 1'b0;
      req_command   = CMD_TO_DATE;
      req_epoch_in  = '0;
      req_second_in = '0;
      req_minute_in = '0;
      req_hour_in   = '0;
      req_day_in    = '0;
      req_month_in  = '0;
      req_year_in   = '0;
      idle_pct      = 0;
      stall_pct     = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed conversions under the reset leap slot
      send_request(CMD_TO_DATE, 32'd0, 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_DATE, 32'hFFFFFFFF, 63, 63, 31, 31, 15, 255);
      send_request(CMD_TO_DATE, 32'd59, 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_DATE, 32'd60, 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_DATE, 32'd86399, 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_DATE, 32'd86400, 0, 0, 0, 1, 1, 0);
      // leap day and the days around it
      send_request(CMD_TO_DATE, 32'(789 * SECS_PER_DAY), 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_DATE, 32'(788 * SECS_PER_DAY + 86399), 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_DATE, 32'(790 * SECS_PER_DAY), 0, 0, 0, 1, 1, 0);
      // last second of a cycle and first of the next
      send_request(CMD_TO_DATE, 32'(1461 * SECS_PER_DAY - 1), 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_DATE, 32'(1461 * SECS_PER_DAY), 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_EPOCH, 32'hFFFFFFFF, 0, 0, 0, 1, 1, 0);
      send_request(CMD_TO_EPOCH, 32'd0, 59, 59, 23, 31, 12, 136);
      send_request(CMD_TO_EPOCH, 32'd0, 0, 0, 0, 29, 2, 2);
      send_request(CMD_TO_EPOCH, 32'd0, 0, 0, 0, 1, 3, 2);
      // bad months
      send_request(CMD_TO_EPOCH, 32'd0, 10, 20, 5, 15, 0, 7);
      send_request(CMD_TO_EPOCH, 32'd0, 10, 20, 5, 15, 13, 7);
      send_request(CMD_TO_EPOCH, 32'd0, 10, 20, 5, 15, 15, 7);
      // day zero wraps the sum
      send_request(CMD_TO_EPOCH, 32'd0, 0, 0, 0, 0, 1, 0);
      // time and year past their ranges, day past the month length
      send_request(CMD_TO_EPOCH, 32'd0, 63, 63, 31, 31, 2, 255);
      send_request(CMD_TO_EPOCH, 32'd0, 0, 0, 0, 31, 4, 128);
      send_request(CMD_TO_EPOCH, 32'd0, 63, 0, 0, 1, 12, 3);
      drain_conversions();

      // random phases, each under a leap slot and an idling mix; every slot and mix is used in two phases
      for (int p = 0; p < 8; p++) begin
         write_leap_slot(2'(p) ^ {2{p[2]}});
         case (p % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 80;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 80;
            end
            default: begin
               idle_pct = 28;
               stall_pct = 28;
            end
         endcase
         repeat (PHASE_ITEMS) random_request();
         drain_conversions();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/edc_pkg.sv
hdl/edc_sec_to_date.sv
hdl/edc_date_to_sec.sv
hdl/epoch_date_converter.sv
tb/sv/edc_result_checker.sv
tb/sv/tb_epoch_date_converter.sv
